@@ rtl/m32k_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m32k_pkg
// Shared constants, stage map and helpers for the Matern 3/2 kernel pipeline.
// ----------------------------------------------------------------------------
package m32k_pkg;

   localparam int Dim     = 3;
   localparam int NPair   = 6;
   localparam int SqrtLat = 34;   // one root bit per stage
   localparam int ExpLat  = 42;   // 21 factor steps, two stages each
   localparam int DivLat  = 63;   // range check plus 62 quotient bits

   // stage index of the register that holds each quantity
   localparam int StMag  = 1;
   localparam int StSq   = 2;
   localparam int StSum  = 3;
   localparam int StR    = StSum + SqrtLat;      // 37
   localparam int StAr   = StR + 1;
   localparam int StT    = StR + 2;
   localparam int StN    = StR + 3;
   localparam int StExp  = StT + ExpLat;         // 81
   localparam int StE    = StExp + 1;
   localparam int StKern = StE + 1;
   localparam int StBe   = StE + 2;
   localparam int StGp   = StBe + 1;
   localparam int StGrad = StBe + 2;
   localparam int StQ    = StN + DivLat;         // 103
   localparam int StBr   = StQ + 1;
   localparam int StHp   = StQ + 2;
   localparam int StHs   = StQ + 3;
   localparam int StOut  = StQ + 4;              // 107

   localparam logic [21:0] TCap = 22'h20_0000;   // 32.0 in Q16.16

   localparam int PairK [NPair] = '{0, 1, 2, 0, 0, 1};
   localparam int PairL [NPair] = '{0, 1, 2, 1, 2, 2};

   // exp(-2^(k-16)) in Q0.62, by repeated rounded squaring of exp(-2^-16)
   function automatic logic [61:0] exp_factor(input int k);
      logic [123:0] sq;
      logic [62:0]  f0;
      logic [61:0]  f;
      f0 = (63'd1 << 62) - (63'd1 << 46) + (63'd1 << 29) - 63'd2731;
      f  = f0[61:0];
      for (int i = 0; i < k; i++) begin
         sq = 124'(f) * 124'(f);
         sq = sq + (124'd1 << 61);
         f  = sq[123:62];
      end
      return f;
   endfunction

   // saturate a magnitude with sign to signed Q16.16
   function automatic logic [31:0] sat_q16(input logic [79:0] mag, input logic neg);
      logic [31:0] res;
      if (neg) begin
         if (mag >= 80'h8000_0000) res = 32'h8000_0000;
         else                      res = 32'd0 - mag[31:0];
      end else begin
         if (mag > 80'h7FFF_FFFF)  res = 32'h7FFF_FFFF;
         else                      res = mag[31:0];
      end
      return res;
   endfunction

endpackage
`default_nettype wire

@@ rtl/m32k_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m32k_sqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module m32k_sqrt import m32k_pkg::*; (
   input  wire logic        clock,
   input  wire logic        adv,
   input  wire logic [65:0] sum_in,
   output logic      [33:0] root_out
);

   logic [67:0] val_ff  [SqrtLat];
   logic [35:0] rem_ff  [SqrtLat];
   logic [33:0] root_ff [SqrtLat];

   for (genvar g = 0; g < SqrtLat; g++) begin : g_stage
      localparam int P = SqrtLat - 1 - g;
      logic [67:0] val_src;
      logic [35:0] rem_src;
      logic [33:0] root_src;
      logic [37:0] rem_sh;
      logic [37:0] trial;

      if (g == 0) begin : g_first
         assign val_src  = 68'(sum_in);
         assign rem_src  = '0;
         assign root_src = '0;
      end else begin : g_next
         assign val_src  = val_ff[g-1];
         assign rem_src  = rem_ff[g-1];
         assign root_src = root_ff[g-1];
      end

      assign rem_sh = {rem_src, val_src[2*P+1 -: 2]};
      assign trial  = {2'b00, root_src, 2'b01};

      always_ff @(posedge clock) begin
         if (adv) begin
            val_ff[g] <= val_src;
            if (rem_sh >= trial) begin
               rem_ff[g]  <= 36'(rem_sh - trial);
               root_ff[g] <= {root_src[32:0], 1'b1};
            end else begin
               rem_ff[g]  <= rem_sh[35:0];
               root_ff[g] <= {root_src[32:0], 1'b0};
            end
         end
      end
   end

   assign root_out = root_ff[SqrtLat-1];

endmodule
`default_nettype wire

@@ rtl/m32k_exp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m32k_exp
// exp(-t) accumulator: per bit of t, a product split into four partials,
// then a sum with rounding back to Q0.62.
// ----------------------------------------------------------------------------
module m32k_exp import m32k_pkg::*; (
   input  wire logic        clock,
   input  wire logic        adv,
   input  wire logic [21:0] t_in,
   output logic      [62:0] acc_out,
   output logic      [21:0] t_out
);

   localparam int NStep = ExpLat / 2;

   logic [3:0][63:0] pp_ff  [NStep];
   logic [62:0]      acca_ff[NStep];
   logic [21:0]      ta_ff  [NStep];
   logic [62:0]      accb_ff[NStep];
   logic [21:0]      tb_ff  [NStep];

   for (genvar k = 0; k < NStep; k++) begin : g_step
      localparam logic [61:0] Fk = exp_factor(k);
      logic [62:0]  acc_src;
      logic [21:0]  t_src;
      logic [127:0] sum;

      if (k == 0) begin : g_first
         assign acc_src = 63'd1 << 62;
         assign t_src   = t_in;
      end else begin : g_next
         assign acc_src = accb_ff[k-1];
         assign t_src   = tb_ff[k-1];
      end

      assign sum = 128'(pp_ff[k][0]) + (128'(pp_ff[k][1]) << 32)
                 + (128'(pp_ff[k][2]) << 32) + (128'(pp_ff[k][3]) << 64)
                 + (128'd1 << 61);

      always_ff @(posedge clock) begin
         if (adv) begin
            pp_ff[k][0] <= 64'(acc_src[31:0])  * 64'(Fk[31:0]);
            pp_ff[k][1] <= 64'(acc_src[31:0])  * 64'(Fk[61:32]);
            pp_ff[k][2] <= 64'(acc_src[62:32]) * 64'(Fk[31:0]);
            pp_ff[k][3] <= 64'(acc_src[62:32]) * 64'(Fk[61:32]);
            acca_ff[k]  <= acc_src;
            ta_ff[k]    <= t_src;
            accb_ff[k]  <= ta_ff[k][k] ? sum[124:62] : acca_ff[k];
            tb_ff[k]    <= ta_ff[k];
         end
      end
   end

   assign acc_out = accb_ff[NStep-1];
   assign t_out   = tb_ff[NStep-1];

endmodule
`default_nettype wire

@@ rtl/m32k_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m32k_div
// One divider lane: floor(num / den) capped at 2^62, restoring, one
// quotient bit per stage.
// ----------------------------------------------------------------------------
module m32k_div import m32k_pkg::*; (
   input  wire logic        clock,
   input  wire logic        adv,
   input  wire logic [95:0] num_in,
   input  wire logic [33:0] den_in,
   output logic      [62:0] quo_out
);

   localparam int NBit = DivLat - 1;

   logic [33:0] rem_ff [DivLat];
   logic [61:0] nlo_ff [DivLat];
   logic [33:0] den_ff [DivLat];
   logic [61:0] quo_ff [DivLat];
   logic        sat_ff [DivLat];

   // quotient of 2^62 or more saturates; otherwise num[95:62] < den
   always_ff @(posedge clock) begin
      if (adv) begin
         sat_ff[0] <= num_in >= {den_in, 62'd0};
         rem_ff[0] <= num_in[95:62];
         nlo_ff[0] <= num_in[61:0];
         den_ff[0] <= den_in;
         quo_ff[0] <= '0;
      end
   end

   for (genvar i = 1; i < DivLat; i++) begin : g_bit
      localparam int B = NBit - i;
      logic [34:0] rem_sh;
      assign rem_sh = {rem_ff[i-1], nlo_ff[i-1][B]};

      always_ff @(posedge clock) begin
         if (adv) begin
            nlo_ff[i] <= nlo_ff[i-1];
            den_ff[i] <= den_ff[i-1];
            sat_ff[i] <= sat_ff[i-1];
            if (rem_sh >= {1'b0, den_ff[i-1]}) begin
               rem_ff[i] <= 34'(rem_sh - {1'b0, den_ff[i-1]});
               quo_ff[i] <= {quo_ff[i-1][60:0], 1'b1};
            end else begin
               rem_ff[i] <= rem_sh[33:0];
               quo_ff[i] <= {quo_ff[i-1][60:0], 1'b0};
            end
         end
      end
   end

   assign quo_out = sat_ff[DivLat-1] ? (63'd1 << 62) : {1'b0, quo_ff[DivLat-1]};

endmodule
`default_nettype wire

@@ rtl/matern32_kernel_with_gradients.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matern32_kernel_with_gradients
// Matern 3/2 covariance with gradient and second-derivative terms for one
// pair of 3-D points per beat, signed Q16.16 with saturation.
// ----------------------------------------------------------------------------
// Each request beat moves through stages StMag to StOut to become its response beat.
// Throughput: one pair per cycle unless the output stalls; the 34-stage root,
//   the 42-stage exp and the six 63-stage divider lanes are fully pipelined.
// The whole pipeline holds only while a response waits and rsp_tready is low.
// Reset (synchronous, active high) empties the pipeline and loads rate_ff
//   with sqrt(3); no clearing pass.
// ----------------------------------------------------------------------------
module matern32_kernel_with_gradients import m32k_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // first_x, first_y, first_z, second_x, second_y, second_z (32 b each)
   input  wire logic [191:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // kernel_value, grad_cov_x/y/z, hess_xx, hess_yy, hess_zz,
   // hess_xy, hess_xz, hess_yz (32 b each)
   output logic      [319:0] rsp_tdata,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [31:0]  csr_data
);

   // ---------------------------------------------------------------- control
   logic adv;                       // every stage moves one step
   logic vld_ff [StMag:StOut];

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[StOut];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = StMag; s <= StOut; s++) vld_ff[s] <= 1'b0;
      end else if (adv) begin
         vld_ff[StMag] <= req_tvalid;
         for (int s = StMag + 1; s <= StOut; s++) vld_ff[s] <= vld_ff[s-1];
      end
   end

   // ---------------------------------------------------------------- rate
   // b = a*a (b_ff) and its Q16.16 diagonal value (bdiag_ff) follow rate_ff.
   logic [31:0] rate_ff;
   logic [63:0] b_ff;
   logic [31:0] bdiag_ff;
   logic [64:0] b_rnd;

   assign csr_ready = 1'b1;
   assign b_rnd     = 65'(b_ff) + 65'd32768;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= 32'd113512;
      end else if (csr_valid) begin
         rate_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      b_ff     <= 64'(rate_ff) * 64'(rate_ff);
      bdiag_ff <= sat_q16(80'(b_rnd[64:16]), 1'b0);
   end

   // ---------------------------------------------------------------- axis lanes
   // d = first - second; magnitude and sign ride along to the divider outputs.
   logic [2:0][31:0] mag_ff [StMag:StQ];
   logic [2:0]       neg_ff [StMag:StQ];
   logic [2:0][63:0] sq_ff;
   logic [65:0]      sum_ff;

   for (genvar k = 0; k < 3; k++) begin : g_axis
      logic [32:0] d;
      if (k < Dim) begin : g_on
         assign d = {req_tdata[32*k+31], req_tdata[32*k +: 32]}
                  - {req_tdata[32*(k+3)+31], req_tdata[32*(k+3) +: 32]};
      end else begin : g_off
         assign d = '0;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            neg_ff[StMag][k] <= d[32];
            mag_ff[StMag][k] <= d[32] ? 32'(33'd0 - d) : d[31:0];
            sq_ff[k]         <= 64'(mag_ff[StMag][k]) * 64'(mag_ff[StMag][k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = StMag + 1; s <= StQ; s++) begin
            mag_ff[s] <= mag_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
         end
         sum_ff <= 66'(sq_ff[0]) + 66'(sq_ff[1]) + 66'(sq_ff[2]);
      end
   end

   // ---------------------------------------------------------------- distance
   logic [33:0] r_root;
   logic [33:0] r_ff  [StAr:StN];
   logic        rz_ff [StAr:StOut];   // coincident points

   m32k_sqrt u_sqrt (
      .clock    (clock),
      .adv      (adv),
      .sum_in   (sum_ff),
      .root_out (r_root)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff[StAr]  <= r_root;
         rz_ff[StAr] <= r_root == '0;
         for (int s = StAr + 1; s <= StN; s++)   r_ff[s]  <= r_ff[s-1];
         for (int s = StAr + 1; s <= StOut; s++) rz_ff[s] <= rz_ff[s-1];
      end
   end

   // t = round(a*r), capped at 32.0
   logic [65:0] ar_ff;
   logic [21:0] t_ff;
   logic [66:0] ar_rnd;

   assign ar_rnd = 67'(ar_ff) + 67'd32768;

   always_ff @(posedge clock) begin
      if (adv) begin
         ar_ff <= 66'(rate_ff) * 66'(r_root);
         t_ff  <= (ar_rnd[66:16] > 51'(TCap)) ? TCap : ar_rnd[37:16];
      end
   end

   // ---------------------------------------------------------------- exp, b*e
   logic [62:0] acc_x;
   logic [21:0] t_x;
   logic [32:0] e_ff;
   logic [21:0] te_ff;
   logic [64:0] bep_lo_ff, bep_hi_ff;
   logic [63:0] kprod;
   logic [97:0] be_sum;
   logic [63:0] be_ff [StBe:StBr];
   logic [31:0] kern_ff [StKern:StOut];
   logic [62:0] acc_rnd;

   m32k_exp u_exp (
      .clock   (clock),
      .adv     (adv),
      .t_in    (t_ff),
      .acc_out (acc_x),
      .t_out   (t_x)
   );

   assign acc_rnd = acc_x + (63'd1 << 29);
   assign kprod   = (64'(te_ff) + 64'd65536) * 64'(e_ff) + (64'd1 << 31);
   assign be_sum  = 98'(bep_lo_ff) + (98'(bep_hi_ff) << 32) + (98'd1 << 31);

   always_ff @(posedge clock) begin
      if (adv) begin
         e_ff           <= t_x[21] ? 33'd0 : acc_rnd[62:30];
         te_ff          <= t_x;
         kern_ff[StKern] <= kprod[63:32];
         bep_lo_ff      <= 65'(e_ff) * 65'(b_ff[31:0]);
         bep_hi_ff      <= 65'(e_ff) * 65'(b_ff[63:32]);
         be_ff[StBe]    <= be_sum[95:32];
         for (int s = StBe + 1; s <= StBr; s++)     be_ff[s]   <= be_ff[s-1];
         for (int s = StKern + 1; s <= StOut; s++) kern_ff[s] <= kern_ff[s-1];
      end
   end

   // ---------------------------------------------------------------- gradients
   logic [2:0][31:0] grad_ff [StGrad:StOut];

   for (genvar k = 0; k < 3; k++) begin : g_grad
      logic [63:0] gp_lo_ff, gp_hi_ff;
      logic [96:0] gsum;
      assign gsum = 97'(gp_lo_ff) + (97'(gp_hi_ff) << 32) + (97'd1 << 31);

      always_ff @(posedge clock) begin
         if (adv) begin
            gp_lo_ff <= 64'(mag_ff[StBe][k]) * 64'(be_ff[StBe][31:0]);
            gp_hi_ff <= 64'(mag_ff[StBe][k]) * 64'(be_ff[StBe][63:32]);
            grad_ff[StGrad][k] <= sat_q16(80'(gsum[96:32]), neg_ff[StGp][k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = StGrad + 1; s <= StOut; s++) grad_ff[s] <= grad_ff[s-1];
      end
   end

   // ---------------------------------------------------------------- pair lanes
   // q = a*|d_k*d_l| / r per pair, then bracket times b*e, merged at the output.
   logic [NPair-1:0][31:0] hess_ff;

   for (genvar p = 0; p < NPair; p++) begin : g_pair
      localparam int  Ik   = PairK[p];
      localparam int  Il   = PairL[p];
      localparam bit  Diag = (Ik == Il);
      localparam bit  On   = (Ik < Dim) && (Il < Dim);

      logic [63:0]  mm_ff;
      logic [63:0]  np_lo_ff, np_hi_ff;
      logic [95:0]  n_ff;
      logic [62:0]  q;
      logic [62:0]  bm_ff;
      logic         bn_br_ff, bn_hp_ff, bn_hs_ff;
      logic [3:0][63:0] hp_ff;
      logic [127:0] hs_ff;
      logic [127:0] hs_rnd;
      logic         q_big;

      m32k_div u_div (
         .clock   (clock),
         .adv     (adv),
         .num_in  (n_ff),
         .den_in  (r_ff[StN]),
         .quo_out (q)
      );

      assign q_big  = q > 63'h1_0000_0000;
      assign hs_rnd = hs_ff + (128'd1 << 47);

      always_ff @(posedge clock) begin
         if (adv) begin
            mm_ff    <= 64'(mag_ff[StR][Ik]) * 64'(mag_ff[StR][Il]);
            np_lo_ff <= 64'(rate_ff) * 64'(mm_ff[31:0]);
            np_hi_ff <= 64'(rate_ff) * 64'(mm_ff[63:32]);
            n_ff     <= 96'(np_lo_ff) + (96'(np_hi_ff) << 32);

            // bracket: 1 - q on the diagonal, -q or +q off it by sign of d_k*d_l
            if (Diag) begin
               bn_br_ff <= q_big;
               bm_ff    <= q_big ? q - 63'h1_0000_0000 : 63'h1_0000_0000 - q;
            end else begin
               bn_br_ff <= (neg_ff[StQ][Ik] == neg_ff[StQ][Il]) && (q != '0);
               bm_ff    <= q;
            end

            hp_ff[0] <= 64'(bm_ff[31:0])  * 64'(be_ff[StBr][31:0]);
            hp_ff[1] <= 64'(bm_ff[31:0])  * 64'(be_ff[StBr][63:32]);
            hp_ff[2] <= 64'(bm_ff[62:32]) * 64'(be_ff[StBr][31:0]);
            hp_ff[3] <= 64'(bm_ff[62:32]) * 64'(be_ff[StBr][63:32]);
            bn_hp_ff <= bn_br_ff;

            hs_ff    <= 128'(hp_ff[0]) + (128'(hp_ff[1]) << 32)
                      + (128'(hp_ff[2]) << 32) + (128'(hp_ff[3]) << 64);
            bn_hs_ff <= bn_hp_ff;

            if (!On)              hess_ff[p] <= '0;
            else if (rz_ff[StHs]) hess_ff[p] <= Diag ? bdiag_ff : 32'd0;
            else                  hess_ff[p] <= sat_q16(80'(hs_rnd[127:48]), bn_hs_ff);
         end
      end

      assign rsp_tdata[32*(4+p) +: 32] = hess_ff[p];
   end

   // ---------------------------------------------------------------- output
   assign rsp_tdata[31:0]  = kern_ff[StOut];
   assign rsp_tdata[127:32] = grad_ff[StOut];

   // ---------------------------------------------------------------- checks
   // an accepted beat always enters the first stage
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> vld_ff[StMag])
      else $error("accepted beat lost at pipeline entry");

   // coincident points: unit kernel, zero gradient, zero cross terms
   a_coincident: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rz_ff[StOut]) |->
         (rsp_tdata[31:0] == 32'h0001_0000) && (rsp_tdata[127:32] == '0) &&
         (rsp_tdata[319:224] == '0))
      else $error("coincident pair gave wrong terms");

   // zero distance forces a zero a*r product
   a_zero_dist: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[StAr] && rz_ff[StAr]) |-> (ar_ff == '0))
      else $error("zero distance with nonzero a*r");

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Matern 3/2 kernel pipeline. Point pairs are
// streamed in with random gaps and the response stream is throttled at random.
// An in-bench integer predictor works out every response field at request
// accept time, using the rate register value in force at that moment. The
// bench covers several rate settings, a long response hold-off and a final
// stretch with no idling.
// ----------------------------------------------------------------------------
module tb_top;
   import m32k_pkg::*;

   localparam int PipeDepth  = 107;          // pipeline depth in stages, StMag to StOut
   localparam int CycleLimit = 400000;
   localparam logic [31:0] RateSqrt3 = 32'd113512;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [191:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [319:0] rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [31:0]  csr_data = '0;

   // pending responses, oldest first, in rsp_tdata layout
   logic [319:0] pending_rsp [$];
   logic [31:0]  rate_shadow = RateSqrt3;
   int           err_count = 0;
   int           cycle_count = 0;
   int           stall_left = 0;
   bit           gaps_on = 1'b1;
   bit           hold_off = 1'b0;

   matern32_kernel_with_gradients dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   // clamp a magnitude plus sign into signed Q16.16
   function automatic logic [31:0] clamp_q16(input logic [63:0] m, input logic n);
      if (n) return (m >= 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - m[31:0];
      return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
   endfunction

   // round-half-up right shift, saturated to 64 bits
   function automatic logic [63:0] shift_round(input logic [128:0] p, input int sh);
      logic [128:0] v;
      v = (p + (129'd1 << (sh - 1))) >> sh;
      return (v >> 64) != 0 ? 64'hFFFF_FFFF_FFFF_FFFF : v[63:0];
   endfunction

   // exp(-t), t in Q16.16, result Q0.32
   function automatic logic [63:0] exp_decay(input logic [63:0] t);
      logic [63:0] f, acc;
      if (t >= 64'(TCap)) return 64'd0;
      f   = (64'd1 << 62) - (64'd1 << 46) + (64'd1 << 29) - 64'd2731;
      acc = 64'd1 << 62;
      for (int k = 0; k < 21; k++) begin
         if (t[k]) acc = shift_round(129'(acc) * 129'(f), 62);
         f = shift_round(129'(f) * 129'(f), 62);
      end
      return (acc + (64'd1 << 29)) >> 30;
   endfunction

   function automatic logic [319:0] kernel_terms(input logic [191:0] pts,
                                                 input logic [31:0] rate);
      logic [32:0]  mag [3];
      logic         neg [3];
      logic signed [32:0] dv;
      logic [67:0]  sum, sq;
      logic [33:0]  r, cand;
      logic [63:0]  a, b, t, e, be, bm, q, pij;
      logic [79:0]  ar;
      logic [128:0] x;
      logic         bn;
      logic [319:0] res;
      int           i, j;
      sum = '0;
      for (int k = 0; k < 3; k++) begin
         dv = 33'(signed'(pts[32*k +: 32])) - 33'(signed'(pts[32*(k+3) +: 32]));
         neg[k] = dv < 0;
         mag[k] = neg[k] ? 33'(-dv) : 33'(dv);
         sum = sum + 68'(mag[k]) * 68'(mag[k]);
      end
      // floor square root, one bit at a time
      r = '0;
      for (int k = 33; k >= 0; k--) begin
         cand = r | (34'd1 << k);
         sq = 68'(cand) * 68'(cand);
         if (sq <= sum) r = cand;
      end
      a  = 64'(rate);
      b  = a * a;
      ar = 80'(a) * 80'(r);
      ar = (ar + 80'd32768) >> 16;
      t  = (ar > 80'(TCap)) ? 64'(TCap) : ar[63:0];
      e  = exp_decay(t);
      be = shift_round(129'(b) * 129'(e), 32);
      res = '0;
      res[31:0] = 32'(((64'd65536 + t) * e + (64'd1 << 31)) >> 32);
      for (int k = 0; k < 3; k++)
         res[32*(1+k) +: 32] = clamp_q16(shift_round(129'(mag[k]) * 129'(be), 32), neg[k]);
      for (int k = 0; k < NPair; k++) begin
         i = PairK[k];
         j = PairL[k];
         if (r == 0) begin
            // coincident points: diagonal is b, cross terms vanish
            res[32*(4+k) +: 32] = (i == j) ? clamp_q16((b + 64'd32768) >> 16, 1'b0) : 32'd0;
         end else begin
            pij = 64'(mag[i]) * 64'(mag[j]);    // exact, below 2^64
            x   = (129'(a) * 129'(pij)) / 129'(r);
            q   = (x >= (129'd1 << 62)) ? (64'd1 << 62) : x[63:0];
            if (i == j) begin
               bn = q > (64'd1 << 32);
               bm = bn ? q - (64'd1 << 32) : (64'd1 << 32) - q;
            end else begin
               bn = (neg[i] == neg[j]) && q != 0;
               bm = q;
            end
            res[32*(4+k) +: 32] = clamp_q16(shift_round(129'(bm) * 129'(be), 48), bn);
         end
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // monitor: register writes, request beats, response check, timeout
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input int field, input logic [31:0] got,
                                  input logic [31:0] want);
      err_count++;
      if (field < 0)
         $display("tb_top: unexpected response beat at cycle %0d", cycle_count);
      else
         $display("tb_top: field %0d mismatch at cycle %0d: got %h want %h",
                  field, cycle_count, got, want);
   endtask

   always @(posedge clock) begin
      logic [319:0] want;
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("tb_top: done, errors");
         $finish;
      end else if (!reset) begin
         if (csr_valid && csr_ready) rate_shadow = csr_data;
         if (req_tvalid && req_tready)
            pending_rsp.push_back(kernel_terms(req_tdata, rate_shadow));
         if (rsp_tvalid && rsp_tready) begin
            if (pending_rsp.size() == 0) begin
               report_mismatch(-1, '0, '0);
            end else begin
               want = pending_rsp.pop_front();
               for (int f = 0; f < 10; f++)
                  if (rsp_tdata[32*f +: 32] !== want[32*f +: 32])
                     report_mismatch(f, rsp_tdata[32*f +: 32], want[32*f +: 32]);
            end
         end
      end
   end

   // response side: random stall bursts, plus the long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready = 1'b0;
      end else if (hold_off) begin
         rsp_tready = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready = 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 11) - 1;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------
   // one request beat; called at a falling edge, returns at one
   task automatic send_pair(input logic [191:0] pts);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = pts;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic end_burst();
      req_tvalid = 1'b0;
   endtask

   // wait out every pending response plus the pipeline depth
   task automatic drain();
      end_burst();
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (PipeDepth + 10) @(negedge clock);
   endtask

   task automatic write_rate(input logic [31:0] v);
      csr_valid = 1'b1;
      csr_data  = v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [191:0] pack_pair(input logic [31:0] p [6]);
      logic [191:0] v;
      for (int k = 0; k < 6; k++) v[32*k +: 32] = p[k];
      return v;
   endfunction

   // random pair: mostly near neighbors at a random spread, some noise,
   // some coincident, some with a single moving axis
   function automatic logic [191:0] random_pair();
      logic [31:0] p [6];
      int          sh, kind, ax;
      kind = $urandom_range(0, 19);
      sh   = $urandom_range(0, 24);
      ax   = $urandom_range(0, 2);
      for (int k = 0; k < 3; k++) begin
         p[k]   = $urandom;
         p[k+3] = p[k] + ($urandom >> (31 - sh)) - (32'd1 << sh);
      end
      if (kind < 2) begin
         for (int k = 3; k < 6; k++) p[k] = $urandom;
      end else if (kind < 4) begin
         for (int k = 3; k < 6; k++) p[k] = p[k-3];
      end else if (kind < 6) begin
         for (int k = 0; k < 3; k++) if (k != ax) p[k+3] = p[k];
      end
      return pack_pair(p);
   endfunction

   task automatic send_random(input int n);
      for (int i = 0; i < n; i++) send_pair(random_pair());
      end_burst();
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   task automatic test_directed();
      logic [31:0] p [6];
      logic [31:0] lo = 32'h8000_0000;
      logic [31:0] hi = 32'h7FFF_FFFF;
      // coincident points, at zero and at both extremes
      p = '{0, 0, 0, 0, 0, 0};                send_pair(pack_pair(p));
      p = '{hi, lo, hi, hi, lo, hi};          send_pair(pack_pair(p));
      // largest and most negative differences, on all axes and mixed
      p = '{hi, hi, hi, lo, lo, lo};          send_pair(pack_pair(p));
      p = '{lo, lo, lo, hi, hi, hi};          send_pair(pack_pair(p));
      p = '{hi, lo, 0, lo, hi, 0};            send_pair(pack_pair(p));
      // one LSB apart, single axis and all axes
      p = '{1, 0, 0, 0, 0, 0};                send_pair(pack_pair(p));
      p = '{0, 0, 32'hFFFF_FFFF, 0, 0, 0};    send_pair(pack_pair(p));
      p = '{1, 1, 1, 0, 0, 0};                send_pair(pack_pair(p));
      // unit distance per axis, both signs
      p = '{32'h1_0000, 0, 0, 0, 0, 0};       send_pair(pack_pair(p));
      p = '{0, 32'hFFFF_0000, 0, 0, 0, 0};    send_pair(pack_pair(p));
      p = '{0, 0, 32'h1_0000, 0, 0, 0};       send_pair(pack_pair(p));
      // cross terms with same and opposite sign differences
      p = '{32'h8000, 32'h8000, 32'h8000, 0, 0, 0};        send_pair(pack_pair(p));
      p = '{32'h8000, 32'hFFFF_8000, 32'h8000, 0, 0, 0};   send_pair(pack_pair(p));
      p = '{32'h3_0000, 32'hFFFE_0000, 32'h1_8000, 0, 0, 0}; send_pair(pack_pair(p));
      // distance near the exp cutoff: t about 32 at the reset rate
      p = '{32'h12_7A00, 0, 0, 0, 0, 0};      send_pair(pack_pair(p));
      p = '{32'h12_7C00, 0, 0, 0, 0, 0};      send_pair(pack_pair(p));
      end_burst();
   endtask

   // rate sweep: extremes and typical values, a random batch at each
   task automatic test_rate_sweep();
      logic [31:0] rates [6];
      rates = '{32'd1, 32'hFFFF_FFFF, 32'h1_0000, 32'h100, $urandom, RateSqrt3};
      foreach (rates[i]) begin
         drain();
         write_rate(rates[i]);
         send_pair(192'd0);                       // coincident: diagonal is b
         send_random(60);
         drain();
      end
   endtask

   // response side held off while requests keep coming, so the pipe backs up
   task automatic test_backpressure();
      fork
         begin
            hold_off = 1'b1;
            repeat (400) @(negedge clock);
            hold_off = 1'b0;
         end
         send_random(250);
      join
      drain();
   endtask

   task automatic test_random_bulk();
      send_random(1000);
      drain();
   endtask

   // last stretch at full rate on both sides
   task automatic test_streaming();
      gaps_on = 1'b0;
      send_random(200);
      drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      drain();
      test_rate_sweep();
      test_backpressure();
      test_random_bulk();
      test_streaming();
      if (err_count == 0) $display("tb_top: done, clean");
      else                $display("tb_top: done, errors");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/m32k_pkg.sv
rtl/m32k_sqrt.sv
rtl/m32k_exp.sv
rtl/m32k_div.sv
rtl/matern32_kernel_with_gradients.sv
test/tb_top.sv
